[rtl/core/tcw_pkg.sv]
// Package for the text console writer: screen geometry, field widths,
// command and character codes, and the controller/datapath interface types.
// Used by every module of the block but tcw_ram; depends on nothing.
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   localparam int CMD_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int CELL_W    = 16;
   localparam int COLOR_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int COLX_W    = COL_W + 1;
   localparam int ROWX_W    = ROW_W + 1;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_FG = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BG = 2'd1;

   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

   localparam logic [CHAR_W-1:0] DEFAULT_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] RESET_CELL   = {DEFAULT_ATTR, CH_SPACE};

   localparam logic [COLX_W-1:0] TAB_STOP = 8'd8;
   localparam logic [COLX_W-1:0] TAB_MASK = ~8'd7;

   localparam logic [COLX_W-1:0] COLS_CMP = COLX_W'(COLUMNS);
   localparam logic [ROWX_W-1:0] ROWS_CMP = ROWX_W'(ROWS);
   localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);

   typedef struct packed {
      logic exec;
      logic fill_step;
      logic capture_read;
      logic load_rsp;
   } tcw_cmd_type;

   typedef struct packed {
      logic exec_fill;
      logic exec_read;
      logic fill_done;
   } tcw_status_type;

endpackage

[rtl/core/text_console_writer.sv]
// Text console writer top level: a character-cell screen with a cursor.
// Joins tcw_ctrl and tcw_datapath; depends on tcw_pkg.
//
// Usage: a transaction on the req_ channel carries one command (put
// character, clear screen, move cursor, read cell); each one yields exactly
// one rsp_ transaction with the cursor after the command, the cell value of
// a read (else 0) and a flag that the screen scrolled. Colors are written
// through csr_we/csr_index/csr_wdata; the user must write them only while
// the block is idle, since the block itself does not enforce it. From
// acceptance to rsp_valid, a put, move or out-of-range read passes the
// response state; a read first captures the cell in the read state; a put
// that scrolls first blanks the bottom row one cell per cycle (rows are
// remapped through a top-row offset, never copied); and a clear first blanks
// all 2000 cells one per cycle through the single RAM write port. The block
// takes one command at a time. After reset, req_ready stays low while the
// screen RAM is filled with gray blanks. A new command is accepted while the
// previous response still waits; if the receiver stalls, the finished
// response is held and the block waits before presenting the next one.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [COL_W-1:0]     req_col,
   input  logic [ROW_W-1:0]     req_row,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COL_W-1:0]     rsp_cursor_col,
   output logic [ROW_W-1:0]     rsp_cursor_row,
   output logic [CELL_W-1:0]    rsp_cell_value,
   output logic                 rsp_scrolled,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wdata
);

   tcw_cmd_type    cmd;
   tcw_status_type status;

   tcw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   tcw_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_col       (req_col),
      .req_row       (req_row),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cell_value(rsp_cell_value),
      .rsp_scrolled  (rsp_scrolled)
   );

endmodule

[rtl/core/tcw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the screen cells of the text console writer.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/tcw_datapath.sv]
// Datapath of the text console writer: cursor, scroll offset, colors,
// fill sweep, screen RAM and the response registers.
// Depends on tcw_pkg and tcw_ram.
module tcw_datapath
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_cmd_type          cmd,
   output tcw_status_type       status,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [COL_W-1:0]     req_col,
   input  logic [ROW_W-1:0]     req_row,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_wdata,
   output logic [COL_W-1:0]     rsp_cursor_col,
   output logic [ROW_W-1:0]     rsp_cursor_row,
   output logic [CELL_W-1:0]    rsp_cell_value,
   output logic                 rsp_scrolled
);

   logic [COLOR_W-1:0] fg_ff, fg_in, bg_ff, bg_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [ROW_W-1:0]   top_ff, top_in;
   logic [ADDR_W-1:0]  fill_addr_ff, fill_addr_in, fill_last_ff, fill_last_in;
   logic               fill_default_ff, fill_default_in;
   logic [CELL_W-1:0]  res_cell_ff, res_cell_in;
   logic               res_scrolled_ff, res_scrolled_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;
   logic [CELL_W-1:0]  out_cell_ff, out_cell_in;
   logic               out_scrolled_ff, out_scrolled_in;

   logic [CHAR_W-1:0]  attr;
   logic [CELL_W-1:0]  blank;
   logic [COLX_W-1:0]  tmp_col;
   logic [ROWX_W-1:0]  tmp_row;
   logic               put_we;
   logic [COL_W-1:0]   put_col;
   logic [CELL_W-1:0]  put_data;
   logic               scroll;
   logic               in_range;
   logic [ROW_W-1:0]   top_next;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [CELL_W-1:0]  ram_wdata, ram_rdata;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                 input logic [ROW_W-1:0] lrow);
      logic [ROWX_W-1:0] sum;
      sum = {1'b0, top} + {1'b0, lrow};
      if (sum >= ROWS_CMP) begin
         sum = sum - ROWS_CMP;
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
      return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

   assign attr  = {bg_ff, fg_ff};
   assign blank = {attr, CH_SPACE};
   assign top_next = (top_ff == ROW_LAST) ? '0 : top_ff + 1'b1;
   assign in_range = ({1'b0, req_col} < COLS_CMP) && ({1'b0, req_row} < ROWS_CMP);

   always_comb begin
      tmp_col  = {1'b0, cur_col_ff};
      tmp_row  = {1'b0, cur_row_ff};
      put_we   = 1'b0;
      put_col  = cur_col_ff;
      put_data = blank;
      scroll   = 1'b0;
      unique case (req_char_code)
         CH_LF: begin
            tmp_col = '0;
            tmp_row = tmp_row + 1'b1;
         end
         CH_CR: begin
            tmp_col = '0;
         end
         CH_BS: begin
            if (cur_col_ff != '0) begin
               tmp_col = tmp_col - 1'b1;
               put_we  = 1'b1;
               put_col = cur_col_ff - 1'b1;
            end
         end
         CH_TAB: begin
            tmp_col = (tmp_col + TAB_STOP) & TAB_MASK;
         end
         default: begin
            put_we   = 1'b1;
            put_data = {attr, req_char_code};
            tmp_col  = tmp_col + 1'b1;
         end
      endcase
      if (tmp_col >= COLS_CMP) begin
         tmp_col = '0;
         tmp_row = tmp_row + 1'b1;
      end
      if (tmp_row >= ROWS_CMP) begin
         scroll  = 1'b1;
         tmp_row = {1'b0, ROW_LAST};
      end
   end

   assign status.exec_fill = ((req_cmd == CMD_PUT) && scroll) || (req_cmd == CMD_CLEAR);
   assign status.exec_read = (req_cmd == CMD_READ) && in_range;
   assign status.fill_done = (fill_addr_ff == fill_last_ff);

   assign ram_we    = (cmd.exec && (req_cmd == CMD_PUT) && put_we) || cmd.fill_step;
   assign ram_waddr = cmd.fill_step ? fill_addr_ff
                                    : cell_addr(phys_row(top_ff, cur_row_ff), put_col);
   assign ram_wdata = cmd.fill_step ? (fill_default_ff ? RESET_CELL : blank) : put_data;
   assign ram_raddr = cell_addr(phys_row(top_ff, req_row), req_col);

   always_comb begin
      fg_in           = fg_ff;
      bg_in           = bg_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      top_in          = top_ff;
      fill_addr_in    = fill_addr_ff;
      fill_last_in    = fill_last_ff;
      fill_default_in = fill_default_ff;
      res_cell_in     = res_cell_ff;
      res_scrolled_in = res_scrolled_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      out_cell_in     = out_cell_ff;
      out_scrolled_in = out_scrolled_ff;

      if (csr_we) begin
         if (csr_index == REG_FG) begin
            fg_in = csr_wdata;
         end else if (csr_index == REG_BG) begin
            bg_in = csr_wdata;
         end
      end

      if (cmd.exec) begin
         res_cell_in     = '0;
         res_scrolled_in = 1'b0;
         unique case (req_cmd)
            CMD_PUT: begin
               cur_col_in      = tmp_col[COL_W-1:0];
               cur_row_in      = tmp_row[ROW_W-1:0];
               res_scrolled_in = scroll;
               if (scroll) begin
                  // The old top row becomes the new bottom row and is blanked.
                  top_in          = top_next;
                  fill_addr_in    = cell_addr(top_ff, '0);
                  fill_last_in    = cell_addr(top_ff, COL_LAST);
                  fill_default_in = 1'b0;
               end
            end
            CMD_CLEAR: begin
               cur_col_in      = '0;
               cur_row_in      = '0;
               top_in          = '0;
               fill_addr_in    = '0;
               fill_last_in    = ADDR_LAST;
               fill_default_in = 1'b0;
            end
            CMD_MOVE: begin
               if (in_range) begin
                  cur_col_in = req_col;
                  cur_row_in = req_row;
               end
            end
            CMD_READ: begin
            end
         endcase
      end

      if (cmd.fill_step) begin
         fill_addr_in = fill_addr_ff + 1'b1;
      end

      if (cmd.capture_read) begin
         res_cell_in = ram_rdata;
      end

      if (cmd.load_rsp) begin
         out_col_in      = cur_col_ff;
         out_row_in      = cur_row_ff;
         out_cell_in     = res_cell_ff;
         out_scrolled_in = res_scrolled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff           <= FG_RESET;
         bg_ff           <= BG_RESET;
         cur_col_ff      <= '0;
         cur_row_ff      <= '0;
         top_ff          <= '0;
         fill_addr_ff    <= '0;
         fill_last_ff    <= ADDR_LAST;
         fill_default_ff <= 1'b1;
      end else begin
         fg_ff           <= fg_in;
         bg_ff           <= bg_in;
         cur_col_ff      <= cur_col_in;
         cur_row_ff      <= cur_row_in;
         top_ff          <= top_in;
         fill_addr_ff    <= fill_addr_in;
         fill_last_ff    <= fill_last_in;
         fill_default_ff <= fill_default_in;
      end
   end

   always_ff @(posedge clock) begin
      res_cell_ff     <= res_cell_in;
      res_scrolled_ff <= res_scrolled_in;
      out_col_ff      <= out_col_in;
      out_row_ff      <= out_row_in;
      out_cell_ff     <= out_cell_in;
      out_scrolled_ff <= out_scrolled_in;
   end

   tcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELLS)
   ) u_screen_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rsp_cursor_col = out_col_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_cell_value = out_cell_ff;
   assign rsp_scrolled   = out_scrolled_ff;

endmodule

[rtl/core/tcw_ctrl.sv]
// Controller of the text console writer: sequences reset fill, command
// execution, screen fills, cell reads and the response handshake.
// Depends on tcw_pkg.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  tcw_status_type status,
   output tcw_cmd_type    cmd
);

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_FILL = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.fill_step = 1'b1;
            if (status.fill_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               priority if (status.exec_fill) begin
                  state_in = S_FILL;
               end else if (status.exec_read) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_done) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            cmd.capture_read = 1'b1;
            state_in         = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/tcw_checker.sv]
// Port-level checker for the text console writer and its bind statement.
// Depends on tcw_pkg and the text_console_writer top level.
module tcw_checker
   import tcw_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [COL_W-1:0]     rsp_cursor_col,
   input logic [ROW_W-1:0]     rsp_cursor_row,
   input logic [CELL_W-1:0]    rsp_cell_value,
   input logic                 rsp_scrolled
);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_col)
         && $stable(rsp_cursor_row) && $stable(rsp_cell_value) && $stable(rsp_scrolled))
      else $error("response changed while stalled");

   // The reported cursor is always on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_col) < COLUMNS) && (32'(rsp_cursor_row) < ROWS))
      else $error("cursor outside the screen");

   // A scroll leaves the cursor at the start of the bottom row.
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> (32'(rsp_cursor_row) == ROWS - 1)
         && (rsp_cursor_col == '0))
      else $error("scroll with cursor off the bottom row start");

   // Commands are handled one at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted on consecutive cycles");

   // The screen fill after reset holds off requests.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
